### rtl/ohlcba_pkg.sv
// Shared types, constants and helper functions of the OHLC bar aggregator.
// Used by every module of the block; has no dependencies of its own.

package ohlcba_pkg;

  // Fixed field widths.
  localparam int unsigned DATE_W   = 27;
  localparam int unsigned TIME_W   = 18;
  localparam int unsigned VOL_IN_W = 32;

  // Defaults of the top-level parameters.
  localparam int unsigned PRICE_BITS_DEF      = 32;
  localparam int unsigned VOLUME_SUM_BITS_DEF = 48;

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned MODE_W  = 3;

  // Word index of the interval register (byte address 4 * index).
  localparam logic [PADDR_W-3:0] REG_INTERVAL_MODE = '0;

  // Bar length selected by the interval register; codes five to seven are
  // legal register contents and never close a bar on a tick.
  typedef enum logic [MODE_W-1:0] {
    MODE_UNSET  = 3'd0,
    MODE_SECOND = 3'd1,
    MODE_MINUTE = 3'd2,
    MODE_HOUR   = 3'd3,
    MODE_DAY    = 3'd4
  } interval_e;

  // hhmm and hh parts of an hhmmss time.
  localparam int unsigned MIN_Q_W = 12;
  localparam int unsigned HR_Q_W  = 5;

  typedef struct packed {
    logic [MIN_Q_W-1:0] hhmm;
    logic [HR_Q_W-1:0]  hh;
  } time_quot_t;

  // Reciprocals for division by 100 and by 10000. For every 18-bit time the
  // rounding error of the reciprocal stays below one unit of the quotient.
  localparam int unsigned RECIP_W        = 19;
  localparam int unsigned PROD_W         = TIME_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV100_RECIP   = 19'd335545;
  localparam int unsigned        DIV100_SHIFT   = 25;
  localparam logic [RECIP_W-1:0] DIV10000_RECIP = 19'd429497;
  localparam int unsigned        DIV10000_SHIFT = 32;

  function automatic logic [MIN_Q_W-1:0] div100(input logic [TIME_W-1:0] t);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(t) * PROD_W'(DIV100_RECIP);
    return prod[DIV100_SHIFT +: MIN_Q_W];
  endfunction

  function automatic logic [HR_Q_W-1:0] div10000(input logic [TIME_W-1:0] t);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(t) * PROD_W'(DIV10000_RECIP);
    return prod[DIV10000_SHIFT +: HR_Q_W];
  endfunction

endpackage

### rtl/ohlcba_cfg_regs.sv
// APB-style configuration register of the OHLC bar aggregator.
// Holds the bar interval mode; depends on ohlcba_pkg.

module ohlcba_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ohlcba_pkg::PADDR_W-1:0] paddr,
  input  logic [ohlcba_pkg::PDATA_W-1:0] pwdata,
  output logic [ohlcba_pkg::PDATA_W-1:0] prdata,
  output logic                           pready,
  output ohlcba_pkg::interval_e          mode_o
);
  import ohlcba_pkg::*;

  interval_e mode_q, mode_d;
  logic      hit;
  logic      wr_en;

  assign pready = 1'b1;
  assign hit    = (paddr[PADDR_W-1:2] == REG_INTERVAL_MODE);
  assign wr_en  = psel && penable && pwrite && hit;

  always_comb begin
    mode_d = mode_q;
    if (wr_en) begin
      mode_d = interval_e'(pwdata[MODE_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_UNSET;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign prdata = hit ? PDATA_W'(mode_q) : '0;
  assign mode_o = mode_q;

endmodule

### rtl/ohlcba_close_detect.sv
// Decides whether a tick falls into a later interval than the open bar.
// Splits the tick time into hhmm and hh parts; depends on ohlcba_pkg.

module ohlcba_close_detect (
  input  ohlcba_pkg::interval_e               mode_i,
  input  logic                                bar_open_i,
  input  logic [ohlcba_pkg::DATE_W-1:0]       tick_date_i,
  input  logic [ohlcba_pkg::TIME_W-1:0]       tick_time_i,
  input  logic [ohlcba_pkg::DATE_W-1:0]       last_date_i,
  input  logic [ohlcba_pkg::TIME_W-1:0]       last_time_i,
  input  ohlcba_pkg::time_quot_t              last_quot_i,
  output ohlcba_pkg::time_quot_t              tick_quot_o,
  output logic                                later_o
);
  import ohlcba_pkg::*;

  time_quot_t tick_quot;
  logic       newer_day;
  logic       later;

  // The quotients of the last time are kept in registers, so only the
  // incoming time goes through the reciprocal multipliers.
  assign tick_quot.hhmm = div100(tick_time_i);
  assign tick_quot.hh   = div10000(tick_time_i);
  assign newer_day      = tick_date_i > last_date_i;

  always_comb begin
    unique case (mode_i)
      MODE_SECOND: later = newer_day || (tick_time_i > last_time_i);
      MODE_MINUTE: later = newer_day || (tick_quot.hhmm > last_quot_i.hhmm);
      MODE_HOUR:   later = newer_day || (tick_quot.hh > last_quot_i.hh);
      MODE_DAY:    later = newer_day;
      default:     later = 1'b0;
    endcase
  end

  assign later_o     = bar_open_i && later;
  assign tick_quot_o = tick_quot;

endmodule

### rtl/ohlcba_unit.sv
// Top level of the OHLC bar aggregator: bar state, tick update and result register.
// Depends on ohlcba_pkg, ohlcba_cfg_regs and ohlcba_close_detect.

// Usage.
// Ticks and cutoff commands enter on the input channel (in_valid_i/in_ready_o);
// every closed bar leaves as one transfer on the output channel
// (out_valid_o/out_ready_i). An item produces at most one bar.
// Each accepted item is folded into the bar state in the cycle of its
// transfer, and the bar it closes appears on the output in the next cycle,
// held in the result register. One item is accepted every cycle; the only
// limit is the single result register: while it holds a bar that the
// receiver has not taken, no new item is accepted. A stalled receiver
// therefore stalls the input after at most one pending bar.
// The interval mode is written over the APB-style port at byte address 0;
// the user must write it only while the block is idle, which the block
// itself does not enforce. Reset leaves no bar open, the output empty and
// the mode unset; in unset mode every item is accepted and ignored.
// A cutoff command closes the open bar; a cutoff with no bar open does nothing.

module ohlc_bar_aggregator_unit #(
  parameter int unsigned PRICE_BITS      = ohlcba_pkg::PRICE_BITS_DEF,
  parameter int unsigned VOLUME_SUM_BITS = ohlcba_pkg::VOLUME_SUM_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ohlcba_pkg::PADDR_W-1:0]  paddr,
  input  logic [ohlcba_pkg::PDATA_W-1:0]  pwdata,
  output logic [ohlcba_pkg::PDATA_W-1:0]  prdata,
  output logic                            pready,
  // Tick channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            command_i,
  input  logic [ohlcba_pkg::DATE_W-1:0]   tick_date_i,
  input  logic [ohlcba_pkg::TIME_W-1:0]   tick_time_i,
  input  logic [PRICE_BITS-1:0]           tick_price_i,
  input  logic [ohlcba_pkg::VOL_IN_W-1:0] tick_volume_i,
  // Bar channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ohlcba_pkg::DATE_W-1:0]   bar_date_o,
  output logic [ohlcba_pkg::TIME_W-1:0]   bar_time_o,
  output logic [PRICE_BITS-1:0]           bar_open_o,
  output logic [PRICE_BITS-1:0]           bar_high_o,
  output logic [PRICE_BITS-1:0]           bar_low_o,
  output logic [PRICE_BITS-1:0]           bar_close_o,
  output logic [VOLUME_SUM_BITS-1:0]      bar_volume_o
);
  import ohlcba_pkg::*;

  interval_e mode;
  logic      in_fire;
  logic      is_cutoff;
  logic      later;
  logic      emit;
  logic      start_bar;
  logic      add_tick;

  time_quot_t tick_quot;

  // Bar state.
  logic                       bar_open_q, bar_open_d;
  logic [DATE_W-1:0]          last_date_q;
  logic [TIME_W-1:0]          last_time_q;
  time_quot_t                 last_quot_q;
  logic [PRICE_BITS-1:0]      open_q, high_q, low_q, close_q;
  logic [VOLUME_SUM_BITS-1:0] vol_q, vol_d;
  logic [VOLUME_SUM_BITS:0]   vol_sum;

  // Result register.
  logic                       out_valid_q, out_valid_d;
  logic [DATE_W-1:0]          res_date_q;
  logic [TIME_W-1:0]          res_time_q;
  logic [PRICE_BITS-1:0]      res_open_q, res_high_q, res_low_q, res_close_q;
  logic [VOLUME_SUM_BITS-1:0] res_vol_q;

  ohlcba_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode)
  );

  ohlcba_close_detect u_close_detect (
    .mode_i      (mode),
    .bar_open_i  (bar_open_q),
    .tick_date_i (tick_date_i),
    .tick_time_i (tick_time_i),
    .last_date_i (last_date_q),
    .last_time_i (last_time_q),
    .last_quot_i (last_quot_q),
    .tick_quot_o (tick_quot),
    .later_o     (later)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_cutoff  = in_fire && (mode != MODE_UNSET) && command_i;
  assign add_tick   = in_fire && (mode != MODE_UNSET) && !command_i;

  // A closing tick both emits the old bar and opens a new one.
  assign emit      = (is_cutoff && bar_open_q) || (add_tick && later);
  assign start_bar = add_tick && (!bar_open_q || later);

  // The extra top bit of the sum flags an overflow, which saturates.
  assign vol_sum = {1'b0, vol_q} + (VOLUME_SUM_BITS + 1)'(tick_volume_i);

  always_comb begin
    if (start_bar) begin
      vol_d = VOLUME_SUM_BITS'(tick_volume_i);
    end else if (vol_sum[VOLUME_SUM_BITS]) begin
      vol_d = '1;
    end else begin
      vol_d = vol_sum[VOLUME_SUM_BITS-1:0];
    end
  end

  always_comb begin
    bar_open_d = bar_open_q;
    if (add_tick) begin
      bar_open_d = 1'b1;
    end else if (is_cutoff) begin
      bar_open_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_open_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_date_q <= '0;
      last_time_q <= '0;
      last_quot_q <= '0;
    end else begin
      bar_open_q  <= bar_open_d;
      out_valid_q <= out_valid_d;
      if (add_tick) begin
        last_date_q <= tick_date_i;
        last_time_q <= tick_time_i;
        last_quot_q <= tick_quot;
      end
    end
  end

  // Prices and the sum are only read while a bar is open.
  always_ff @(posedge clk_i) begin
    if (add_tick) begin
      close_q <= tick_price_i;
      vol_q   <= vol_d;
      if (start_bar) begin
        open_q <= tick_price_i;
        high_q <= tick_price_i;
        low_q  <= tick_price_i;
      end else begin
        if (tick_price_i > high_q) begin
          high_q <= tick_price_i;
        end
        if (tick_price_i < low_q) begin
          low_q <= tick_price_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_date_q  <= last_date_q;
      res_time_q  <= last_time_q;
      res_open_q  <= open_q;
      res_high_q  <= high_q;
      res_low_q   <= low_q;
      res_close_q <= close_q;
      res_vol_q   <= vol_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bar_date_o   = res_date_q;
  assign bar_time_o   = res_time_q;
  assign bar_open_o   = res_open_q;
  assign bar_high_o   = res_high_q;
  assign bar_low_o    = res_low_q;
  assign bar_close_o  = res_close_q;
  assign bar_volume_o = res_vol_q;

  // In unset mode an accepted item never produces a bar.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (mode == MODE_UNSET)) |=> !out_valid_q)
    else $error("bar emitted in unset mode");

  // A cutoff with no open bar produces nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && command_i && !bar_open_q) |=> !out_valid_q)
    else $error("bar emitted by cutoff with no open bar");

  // A tick accepted outside unset mode always leaves a bar open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (add_tick) |=> bar_open_q)
    else $error("no bar open after a tick");

  // An open bar never has a low above its high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (add_tick && !start_bar) |=> (low_q <= high_q))
    else $error("bar low above bar high");

endmodule

### test/testbench.sv
// Self-checking testbench of the OHLC bar aggregator: directed table, then random tick streams.
// Bars are taken from the table or an in-bench model of bar state and compared field by field.
// Depends on ohlcba_pkg and ohlc_bar_aggregator_unit.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ohlcba_pkg::*;

  localparam int unsigned PRICE_W = 32;
  localparam int unsigned VSUM_W  = 48;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_CUTOFF = 1'b1;

  // Register codes beyond the named intervals; they never close a bar on a tick.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  localparam logic [DATE_W-1:0]   DATE_MAX   = 27'd99991231;
  localparam logic [TIME_W-1:0]   TIME_MAX   = 18'd235959;
  localparam logic [PRICE_W-1:0]  PRICE_MAX  = '1;
  localparam logic [VOL_IN_W-1:0] VOL_IN_MAX = '1;
  localparam logic [VSUM_W-1:0]   VSUM_MAX   = '1;

  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam longint LIMIT_NS  = 64'd10_000_000;

  typedef struct packed {
    logic                cmd;
    logic [DATE_W-1:0]   tdate;
    logic [TIME_W-1:0]   ttime;
    logic [PRICE_W-1:0]  price;
    logic [VOL_IN_W-1:0] volume;
  } tick_t;

  typedef struct packed {
    logic [DATE_W-1:0]  stamp_date;
    logic [TIME_W-1:0]  stamp_time;
    logic [PRICE_W-1:0] open_p;
    logic [PRICE_W-1:0] high_p;
    logic [PRICE_W-1:0] low_p;
    logic [PRICE_W-1:0] close_p;
    logic [VSUM_W-1:0]  vol;
  } bar_t;

  typedef struct {
    bit                is_cfg;
    logic [MODE_W-1:0] mode;
    tick_t             tk;
    bit                typed;
    bar_t              bar;
  } plan_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic                command_i     = 1'b0;
  logic [DATE_W-1:0]   tick_date_i   = '0;
  logic [TIME_W-1:0]   tick_time_i   = '0;
  logic [PRICE_W-1:0]  tick_price_i  = '0;
  logic [VOL_IN_W-1:0] tick_volume_i = '0;

  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [DATE_W-1:0]  bar_date_o;
  logic [TIME_W-1:0]  bar_time_o;
  logic [PRICE_W-1:0] bar_open_o;
  logic [PRICE_W-1:0] bar_high_o;
  logic [PRICE_W-1:0] bar_low_o;
  logic [PRICE_W-1:0] bar_close_o;
  logic [VSUM_W-1:0]  bar_volume_o;

  ohlc_bar_aggregator_unit #(
    .PRICE_BITS      (PRICE_W),
    .VOLUME_SUM_BITS (VSUM_W)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .tick_date_i   (tick_date_i),
    .tick_time_i   (tick_time_i),
    .tick_price_i  (tick_price_i),
    .tick_volume_i (tick_volume_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bar_date_o    (bar_date_o),
    .bar_time_o    (bar_time_o),
    .bar_open_o    (bar_open_o),
    .bar_high_o    (bar_high_o),
    .bar_low_o     (bar_low_o),
    .bar_close_o   (bar_close_o),
    .bar_volume_o  (bar_volume_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #(LIMIT_NS);
    $display("testbench: FAIL");
    $finish;
  end

  // Bar state as the block should hold it.
  logic [MODE_W-1:0]  mode_q = MODE_UNSET;
  bit                 bar_live_q = 1'b0;
  logic [DATE_W-1:0]  date_q = '0;
  logic [TIME_W-1:0]  time_q = '0;
  logic [PRICE_W-1:0] open_q = '0;
  logic [PRICE_W-1:0] high_q = '0;
  logic [PRICE_W-1:0] low_q = '0;
  logic [PRICE_W-1:0] close_q = '0;
  logic [VSUM_W-1:0]  sum_q = '0;

  bar_t      bar_expected[$];
  plan_row_t plan[$];
  int        err_count = 0;
  int        burst_left = 0;
  bit        hold_req = 1'b0;

  // Random walk of the tick stream.
  int              walk_sod = 0;
  int              walk_date = 20240101;
  logic [PRICE_W-1:0] walk_price = 32'd10000;

  function automatic void note_bar(input bar_t b);
    bar_expected.insert(bar_expected.size(), b);
  endfunction

  function automatic void plan_add(input plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  task automatic close_current(output bit closed, output bar_t bar);
    closed = 1'b0;
    bar = '0;
    if (mode_q == MODE_UNSET || !bar_live_q) return;
    bar = '{date_q, time_q, open_q, high_q, low_q, close_q, sum_q};
    closed = 1'b1;
    bar_live_q = 1'b0;
    open_q = '0;
    high_q = '0;
    low_q = '0;
    close_q = '0;
    sum_q = '0;
  endtask

  task automatic fold_item(input tick_t tk, output bit closed, output bar_t bar);
    bit later;
    bit newer_day;
    later = 1'b0;
    closed = 1'b0;
    bar = '0;
    if (mode_q == MODE_UNSET) return;
    if (tk.cmd == CMD_CUTOFF) begin
      close_current(closed, bar);
      return;
    end
    if (bar_live_q) begin
      newer_day = tk.tdate > date_q;
      case (mode_q)
        MODE_SECOND: later = newer_day || tk.ttime > time_q;
        MODE_MINUTE: later = newer_day || (int'(tk.ttime) / 100) > (int'(time_q) / 100);
        MODE_HOUR:   later = newer_day || (int'(tk.ttime) / 10000) > (int'(time_q) / 10000);
        MODE_DAY:    later = newer_day;
        default:     later = 1'b0;
      endcase
    end
    if (later) close_current(closed, bar);
    date_q = tk.tdate;
    time_q = tk.ttime;
    if (!bar_live_q) begin
      open_q = tk.price;
      high_q = tk.price;
      low_q = tk.price;
      close_q = tk.price;
      sum_q = VSUM_W'(tk.volume);
      bar_live_q = 1'b1;
    end else begin
      if (tk.price > high_q) high_q = tk.price;
      if (tk.price < low_q) low_q = tk.price;
      close_q = tk.price;
      if (VSUM_W'(tk.volume) > VSUM_MAX - sum_q) sum_q = VSUM_MAX;
      else sum_q = sum_q + VSUM_W'(tk.volume);
    end
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin : bar_check
    bar_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bar_expected.size() == 0) begin
        $display("%0t: bar transfer with none expected, expected nothing, got date %0d time %0d",
                 $time, bar_date_o, bar_time_o);
        err_count++;
      end else begin
        want = bar_expected[0];
        bar_expected.delete(0);
        check_field("bar_date", 64'(want.stamp_date), 64'(bar_date_o));
        check_field("bar_time", 64'(want.stamp_time), 64'(bar_time_o));
        check_field("bar_open", 64'(want.open_p), 64'(bar_open_o));
        check_field("bar_high", 64'(want.high_p), 64'(bar_high_o));
        check_field("bar_low", 64'(want.low_p), 64'(bar_low_o));
        check_field("bar_close", 64'(want.close_p), 64'(bar_close_o));
        check_field("bar_volume", 64'(want.vol), 64'(bar_volume_o));
      end
    end
  end

  // Receiver: runs of steady acceptance, coin flips and short stalls, plus one long hold-off
  // on request so that a pending bar backs up into the tick channel.
  initial begin : sink_pace
    int run;
    int style;
    forever begin
      style = $urandom_range(3, 0);
      run = (style == 3) ? $urandom_range(8, 1) : $urandom_range(40, 1);
      repeat (run) begin
        @(posedge clk_i);
        if (hold_req) begin
          hold_req = 1'b0;
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        case (style)
          0, 1: out_ready_i <= 1'b1;
          2: out_ready_i <= 1'($urandom_range(1, 0));
          default: out_ready_i <= 1'b0;
        endcase
      end
    end
  end

  task automatic send_item(input tick_t tk, input bit typed, input bar_t typed_bar);
    bit   closed;
    bar_t bar;
    int   gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6, 0);
      burst_left = $urandom_range(24, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    command_i     <= tk.cmd;
    tick_date_i   <= tk.tdate;
    tick_time_i   <= tk.ttime;
    tick_price_i  <= tk.price;
    tick_volume_i <= tk.volume;
    do @(posedge clk_i); while (!in_ready_o);
    fold_item(tk, closed, bar);
    if (typed) note_bar(typed_bar);
    else if (closed) note_bar(bar);
  endtask

  // Stops offering ticks and waits until every predicted bar has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (bar_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [MODE_W-1:0] m);
    drain();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_INTERVAL_MODE, 2'b00};
    pwdata  <= PDATA_W'(m);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mode_q = m;
  endtask

  function automatic plan_row_t cfg_row(input logic [MODE_W-1:0] m);
    plan_row_t r;
    r = '{1'b1, m, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t item_row(input logic c, input int unsigned d, input int unsigned t,
                                         input logic [PRICE_W-1:0] p,
                                         input logic [VOL_IN_W-1:0] v);
    plan_row_t r;
    r = '{1'b0, MODE_UNSET, '{c, DATE_W'(d), TIME_W'(t), p, v}, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t bar_row(input logic c, input int unsigned d, input int unsigned t,
                                        input logic [PRICE_W-1:0] p,
                                        input logic [VOL_IN_W-1:0] v, input bar_t b);
    plan_row_t r;
    r = item_row(c, d, t, p, v);
    r.typed = 1'b1;
    r.bar = b;
    return r;
  endfunction

  // Next tick of a mostly ordered stream: time moves forward by up to scale seconds, with
  // occasional cutoffs, out-of-order jumps and ticks at arbitrary stamps.
  task automatic next_tick(input int scale, output tick_t tk);
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 3) walk_sod = $urandom_range(86399, 0);
    else begin
      walk_sod += $urandom_range(scale, 0);
      if (walk_sod > 86399) begin
        walk_sod -= 86400;
        walk_date = (walk_date >= int'(DATE_MAX)) ? 0 : walk_date + 1;
      end
    end
    case ($urandom_range(9, 0))
      0: walk_price = '0;
      1: walk_price = PRICE_MAX;
      2, 3: walk_price = $urandom;
      default: walk_price = walk_price + PRICE_W'($urandom_range(200, 0)) - PRICE_W'(100);
    endcase
    tk.cmd = (roll >= 95) ? CMD_CUTOFF : CMD_TICK;
    tk.tdate = DATE_W'(walk_date);
    tk.ttime = TIME_W'((walk_sod / 3600) * 10000 + ((walk_sod / 60) % 60) * 100 + walk_sod % 60);
    if (roll >= 85 && roll < 95) begin
      tk.tdate = DATE_W'($urandom_range(DATE_MAX, 0));
      tk.ttime = TIME_W'($urandom_range(TIME_MAX, 0));
    end
    tk.price = walk_price;
    case ($urandom_range(7, 0))
      0: tk.volume = '0;
      1: tk.volume = VOL_IN_MAX;
      2, 3: tk.volume = $urandom;
      default: tk.volume = VOL_IN_W'($urandom_range(100000, 0));
    endcase
  endtask

  task automatic random_phase(input logic [MODE_W-1:0] m, input int count, input int hold_at,
                              input int pause_at);
    tick_t tk;
    int    scale;
    reconfigure(m);
    case (m)
      MODE_SECOND: scale = 2;
      MODE_MINUTE: scale = 60;
      MODE_HOUR:   scale = 1800;
      default:     scale = 20000;
    endcase
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) drain();
      next_tick(scale, tk);
      send_item(tk, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Unset mode after reset: everything is ignored.
    plan_add(item_row(CMD_TICK, 20240102, 93000, 1000, 5));
    plan_add(item_row(CMD_CUTOFF, 20240102, 93000, 1000, 5));
    plan_add(cfg_row(MODE_SECOND));
    // Cutoff with no bar open.
    plan_add(item_row(CMD_CUTOFF, 1, 1, 1, 1));
    plan_add(item_row(CMD_TICK, DATE_MAX, 0, 0, VOL_IN_MAX));
    plan_add(item_row(CMD_TICK, DATE_MAX, 0, PRICE_MAX, VOL_IN_MAX));
    // Earlier date but later time still closes the bar.
    plan_add(bar_row(CMD_TICK, 0, 1, 5, 1,
                     '{DATE_MAX, 0, 0, PRICE_MAX, 0, PRICE_MAX, 48'h1_FFFF_FFFE}));
    // The cutoff's own fields play no part.
    plan_add(bar_row(CMD_CUTOFF, DATE_MAX, TIME_MAX, PRICE_MAX, VOL_IN_MAX,
                     '{0, 1, 5, 5, 5, 5, 1}));
    plan_add(item_row(CMD_CUTOFF, 0, 0, 0, 0));
    plan_add(item_row(CMD_TICK, 20240102, 235959, 42, 0));
    plan_add(item_row(CMD_TICK, 20240101, 235959, 7, 3));
    plan_add(bar_row(CMD_CUTOFF, 0, 0, 0, 0,
                     '{20240101, 235959, 42, 42, 7, 7, 3}));
    plan_add(cfg_row(MODE_MINUTE));
    plan_add(item_row(CMD_TICK, 1, 120000, 100, 10));
    plan_add(item_row(CMD_TICK, 1, 120059, 50, 20));
    plan_add(bar_row(CMD_TICK, 1, 120100, 70, 0,
                     '{1, 120059, 100, 100, 50, 50, 30}));
    plan_add(cfg_row(MODE_HOUR));
    plan_add(item_row(CMD_TICK, 1, 125959, 90, 1));
    plan_add(item_row(CMD_TICK, 1, 130000, 60, 2));
    plan_add(cfg_row(MODE_DAY));
    plan_add(item_row(CMD_TICK, 1, 235959, 80, 4));
    plan_add(item_row(CMD_TICK, 2, 0, 65, 5));
    plan_add(cfg_row(MODE_SPARE_HI));
    plan_add(item_row(CMD_TICK, 3, 0, 1, 6));
    plan_add(item_row(CMD_TICK, 4, 235959, 2, 7));
    plan_add(item_row(CMD_CUTOFF, 0, 0, 0, 0));
    plan_add(item_row(CMD_TICK, 5, 100, 33, 8));
    // Unset mode freezes the open bar until a mode is set again.
    plan_add(cfg_row(MODE_UNSET));
    plan_add(item_row(CMD_TICK, 6, 200, 44, 9));
    plan_add(item_row(CMD_CUTOFF, 6, 200, 44, 9));
    plan_add(cfg_row(MODE_SECOND));
    plan_add(bar_row(CMD_CUTOFF, 0, 0, 0, 0, '{5, 100, 33, 33, 33, 33, 8}));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) reconfigure(plan[i].mode);
      else send_item(plan[i].tk, plan[i].typed, plan[i].bar);
    end

    walk_date = $urandom_range(DATE_MAX - 1000, 0);
    random_phase(MODE_SECOND, 250, 60, -1);
    random_phase(MODE_MINUTE, 250, -1, -1);
    random_phase(MODE_HOUR, 250, -1, 120);
    random_phase(MODE_DAY, 250, -1, -1);
    random_phase(MODE_SPARE_LO, 250, -1, -1);
    random_phase(MODE_SPARE_HI, 250, -1, -1);
    random_phase(MODE_UNSET, 40, -1, -1);
    random_phase(MODE_SECOND, 250, -1, -1);

    drain();
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
